[rtl/sobel_edge_magnitude_rgb_top_macros.svh]
// Assertion helpers for the Sobel edge block.
// SYNTH selects the empty bodies for synthesis runs.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_TOP_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SOBEL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define SOBEL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SOBEL_ASSERT_IMP(lbl, ante, cons, msg)
`define SOBEL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/sobel_pkg.sv]
`default_nettype none
package sobel_pkg;

  localparam int PixW       = 24;
  localparam int ChW        = 8;
  localparam int NumCh      = 3;
  // Gradients span -1020..1020; their squared sum stays below 2^21.
  localparam int GradW      = 11;
  localparam int SumW       = 21;
  localparam int RowW       = 16;
  localparam int ColOutW    = 10;
  localparam int WidthRegW  = 11;
  localparam int HeightRegW = 16;
  localparam int CfgIdxW    = 1;
  localparam int CfgDataW   = 16;
  localparam int InTdataW   = 24;
  localparam int OutTdataW  = 56;
  localparam int MaxWidthDef = 1024;

  // Above 255*255+255 the rounded magnitude saturates.
  localparam int SatLimit = 65280;
  localparam logic [ChW-1:0] ChMax = 8'd255;

  localparam logic [WidthRegW-1:0]  WidthRst  = 11'd640;
  localparam logic [HeightRegW-1:0] HeightRst = 16'd480;

  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 1'b1;

  // 3x3 pixel block, indexed [row][col], row 0 on top.
  typedef logic [2:0][2:0][PixW-1:0] win_t;
  // Per-channel gx*gx + gy*gy.
  typedef logic [NumCh-1:0][SumW-1:0] sums_t;

endpackage
`default_nettype wire

[rtl/sobel_line_mem.sv]
`default_nettype none
// Line store: upper row in the high half of a word, lower row in the low half.
module sobel_line_mem #(
  parameter int Depth = sobel_pkg::MaxWidthDef,
  parameter int Width = 2 * sobel_pkg::PixW,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AddrW-1:0] rd_addr_i,
  output logic      [Width-1:0] rd_data_o,
  input  wire logic             wr_en_i,
  input  wire logic [AddrW-1:0] wr_addr_i,
  input  wire logic [Width-1:0] wr_data_i
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/sobel_grad.sv]
`default_nettype none
// Two stages: Sobel gradients per channel, then the sum of their squares.
module sobel_grad (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire sobel_pkg::win_t nb_i,
  output logic               valid_o,
  output sobel_pkg::sums_t   sums_o
);
  import sobel_pkg::*;

  logic v1_q, v2_q;
  logic [NumCh-1:0][GradW-1:0] gx_q, gy_q, gx_d, gy_d;
  sums_t sums_q, sums_d;

  always_comb begin
    logic [GradW:0] xp, xn, yp, yn;
    for (int ch = 0; ch < NumCh; ch++) begin
      xp = {4'b0, nb_i[0][2][ch*ChW +: ChW]} + {3'b0, nb_i[1][2][ch*ChW +: ChW], 1'b0}
         + {4'b0, nb_i[2][2][ch*ChW +: ChW]};
      xn = {4'b0, nb_i[0][0][ch*ChW +: ChW]} + {3'b0, nb_i[1][0][ch*ChW +: ChW], 1'b0}
         + {4'b0, nb_i[2][0][ch*ChW +: ChW]};
      yp = {4'b0, nb_i[2][0][ch*ChW +: ChW]} + {3'b0, nb_i[2][1][ch*ChW +: ChW], 1'b0}
         + {4'b0, nb_i[2][2][ch*ChW +: ChW]};
      yn = {4'b0, nb_i[0][0][ch*ChW +: ChW]} + {3'b0, nb_i[0][1][ch*ChW +: ChW], 1'b0}
         + {4'b0, nb_i[0][2][ch*ChW +: ChW]};
      gx_d[ch] = GradW'(xp - xn);
      gy_d[ch] = GradW'(yp - yn);
    end
  end

  always_comb begin
    logic signed [2*GradW-1:0] sqx, sqy;
    for (int ch = 0; ch < NumCh; ch++) begin
      sqx = $signed(gx_q[ch]) * $signed(gx_q[ch]);
      sqy = $signed(gy_q[ch]) * $signed(gy_q[ch]);
      sums_d[ch] = SumW'(sqx) + SumW'(sqy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
    if (v1_q) begin
      sums_q <= sums_d;
    end
  end

  assign valid_o = v2_q;
  assign sums_o  = sums_q;

endmodule
`default_nettype wire

[rtl/sobel_sqrt.sv]
`default_nettype none
// Rounded square root per channel: one result bit per cycle, then a rounding step.
module sobel_sqrt (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire sobel_pkg::sums_t           s_i,
  output logic                            done_o,
  output logic [sobel_pkg::PixW-1:0]      mag_o
);
  import sobel_pkg::*;

  localparam int StepW = $clog2(ChW);

  logic             busy_q, rnd_q, done_q;
  logic [StepW-1:0] step_q;
  logic [NumCh-1:0][2*ChW-1:0] s_q;
  logic [NumCh-1:0]            sat_q;
  logic [NumCh-1:0][ChW-1:0]   n_q, n_d, rnd_d;
  logic [PixW-1:0]             mag_q;

  always_comb begin
    logic [ChW-1:0]     bitv, t;
    logic [2*ChW-1:0]   tsq;
    logic [2*ChW:0]     upper;
    bitv = ChW'(1) << step_q;
    for (int ch = 0; ch < NumCh; ch++) begin
      t   = n_q[ch] | bitv;
      tsq = t * t;
      n_d[ch] = (tsq <= s_q[ch]) ? t : n_q[ch];
      upper = (2*ChW+1)'(n_q[ch] * n_q[ch]) + (2*ChW+1)'(n_q[ch]);
      if (sat_q[ch]) begin
        rnd_d[ch] = ChMax;
      end else if ((2*ChW+1)'(s_q[ch]) > upper) begin
        rnd_d[ch] = n_q[ch] + ChW'(1);
      end else begin
        rnd_d[ch] = n_q[ch];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= rnd_q;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= StepW'(ChW - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          rnd_q  <= 1'b1;
        end else begin
          step_q <= step_q - StepW'(1);
        end
      end else if (rnd_q) begin
        rnd_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int ch = 0; ch < NumCh; ch++) begin
        s_q[ch]   <= s_i[ch][2*ChW-1:0];
        sat_q[ch] <= s_i[ch] > SumW'(SatLimit);
        n_q[ch]   <= '0;
      end
    end else if (busy_q) begin
      n_q <= n_d;
    end else if (rnd_q) begin
      for (int ch = 0; ch < NumCh; ch++) begin
        mag_q[ch*ChW +: ChW] <= rnd_d[ch];
      end
    end
  end

  assign done_o = done_q;
  assign mag_o  = mag_q;

endmodule
`default_nettype wire

[rtl/sobel_edge_magnitude_rgb_top.sv]
// Sobel 3x3 edge magnitude on RGB pixels, one input pixel in work at a time.
// An input pixel releases 0 to 4 results, one at a time, and the
// eight-step square-root unit sets the time that each result takes.
// Results trail their input by one row and one column, as the window requires.
// Reset (rst_ni low, asynchronous) clears counters, window and output state
// and loads 640 x 480; the line store needs no clearing pass.
`default_nettype none
`include "sobel_edge_magnitude_rgb_top_macros.svh"
module sobel_edge_magnitude_rgb_top #(
  parameter int MaxWidth = sobel_pkg::MaxWidthDef
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration writes, taken whenever cfg_we_i is high.
  input  wire logic                              cfg_we_i,
  input  wire logic [sobel_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [sobel_pkg::CfgDataW-1:0]    cfg_wdata_i,
  // Input pixel stream.
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // tdata: in_pixel [23:0].
  input  wire logic [sobel_pkg::InTdataW-1:0]    s_axis_tdata_i,
  // Result stream.
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // tdata: out_pixel [23:0], out_row [39:24], out_col [49:40], zeros above.
  output logic [sobel_pkg::OutTdataW-1:0]        m_axis_tdata_o,
  // tlast: last_of_run, set on the final result released by an input pixel.
  output logic                                   m_axis_tlast_o
);
  import sobel_pkg::*;

  // Column counter and line store address width, and a width wide enough to
  // compare the width register against MaxWidth.
  localparam int ColW = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int WdW  = ($clog2(MaxWidth + 1) > WidthRegW) ? $clog2(MaxWidth + 1) : WidthRegW;

  // Sequencer states. Load sees the line store data, Grad launches one
  // result, Wait covers the arithmetic, Emit hands the result to the output.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StLoad = 3'd1;
  localparam logic [2:0] StGrad = 3'd2;
  localparam logic [2:0] StWait = 3'd3;
  localparam logic [2:0] StEmit = 3'd4;

  logic [2:0] state_q, state_d;

  logic [WidthRegW-1:0]  width_q;
  logic [HeightRegW-1:0] height_q;
  logic                  cfg_hit;

  logic [RowW-1:0] row_cnt_q;
  logic [ColW-1:0] col_cnt_q;

  logic [WdW-1:0]        w_ext, w_eff;
  logic [HeightRegW-1:0] h_eff;
  logic                  in_range, r_last_fix, c_last_fix, accept;
  logic [RowW-1:0]       r_fix;
  logic [ColW-1:0]       c_fix;

  // The pixel in work and where it sits.
  logic [PixW-1:0] pix_q;
  logic [RowW-1:0] r_q;
  logic [ColW-1:0] c_q;
  logic            r_last_q, c_last_q;

  // Which result is in work: rsel picks row r-1 (0) or r (1), csel likewise.
  logic rsel_q, rsel_d, csel_q, csel_d;
  logic more_col, more_row, last_res, out_load;

  win_t win_q;
  win_t nb;
  logic [2:0] row_ok, col_ok;

  logic [2*PixW-1:0] mem_rd;

  logic  sqrt_done;
  logic  grad_valid;
  sums_t grad_sums;
  logic [PixW-1:0] mag;

  logic                 m_tvalid_q, m_tlast_q;
  logic [OutTdataW-1:0] m_tdata_q;
  logic [RowW-1:0]      out_row;
  logic [ColW-1:0]      out_col;

  // ---------------------------------------------------------------------------
  // Configuration. Any write to a known register restarts the image.
  // ---------------------------------------------------------------------------
  always_comb begin
    cfg_hit = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgImageWidth:  cfg_hit = 1'b1;
        CfgImageHeight: cfg_hit = 1'b1;
        default:        cfg_hit = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthRst;
      height_q <= HeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgImageWidth:  width_q  <= cfg_wdata_i[WidthRegW-1:0];
        CfgImageHeight: height_q <= cfg_wdata_i[HeightRegW-1:0];
        default: ;
      endcase
    end
  end

  // Zero width or height counts as one; widths beyond the line store clamp.
  assign w_ext = WdW'(width_q);
  assign w_eff = (w_ext == '0) ? WdW'(1) :
                 (w_ext > WdW'(MaxWidth)) ? WdW'(MaxWidth) : w_ext;
  assign h_eff = (height_q == '0) ? HeightRegW'(1) : height_q;

  // ---------------------------------------------------------------------------
  // Raster position of the next input pixel.
  // ---------------------------------------------------------------------------
  assign in_range   = (row_cnt_q < h_eff) && (WdW'(col_cnt_q) < w_eff);
  assign r_fix      = in_range ? row_cnt_q : '0;
  assign c_fix      = in_range ? col_cnt_q : '0;
  assign r_last_fix = (r_fix == h_eff - HeightRegW'(1));
  assign c_last_fix = (WdW'(c_fix) == w_eff - WdW'(1));

  assign s_axis_tready_o = (state_q == StIdle);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
    end else if (cfg_hit) begin
      row_cnt_q <= '0;
      col_cnt_q <= '0;
    end else if (accept) begin
      if (c_last_fix) begin
        col_cnt_q <= '0;
        row_cnt_q <= r_last_fix ? '0 : r_fix + RowW'(1);
      end else begin
        col_cnt_q <= c_fix + ColW'(1);
        row_cnt_q <= r_fix;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q    <= s_axis_tdata_i[PixW-1:0];
      r_q      <= r_fix;
      c_q      <= c_fix;
      r_last_q <= r_last_fix;
      c_last_q <= c_last_fix;
    end
  end

  // ---------------------------------------------------------------------------
  // Line store. It is read at the accept edge and written back in Load, so a
  // read never meets a pending write to the same column.
  // ---------------------------------------------------------------------------
  sobel_line_mem #(
    .Depth (MaxWidth),
    .Width (2 * PixW),
    .AddrW (ColW)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (c_fix),
    .rd_data_o (mem_rd),
    .wr_en_i   (state_q == StLoad),
    .wr_addr_i (c_q),
    .wr_data_i ({mem_rd[PixW-1:0], pix_q})
  );

  // Window shift: rows r-2..r, columns c-2..c after the update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (state_q == StLoad) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= mem_rd[2*PixW-1:PixW];
      win_q[1][2] <= mem_rd[PixW-1:0];
      win_q[2][2] <= pix_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Neighborhood of the result in work. Neighbors outside the image read as
  // zero, which also hides stale and never-written line store entries.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [1:0] ri, ci;
    row_ok[0] = rsel_q ? (r_q != '0) : (r_q > RowW'(1));
    row_ok[1] = 1'b1;
    row_ok[2] = !rsel_q;
    col_ok[0] = csel_q ? (c_q != '0) : (c_q > ColW'(1));
    col_ok[1] = 1'b1;
    col_ok[2] = !csel_q;
    for (int dr = 0; dr < 3; dr++) begin
      for (int dc = 0; dc < 3; dc++) begin
        ri = 2'(dr) + {1'b0, rsel_q};
        ci = 2'(dc) + {1'b0, csel_q};
        if (row_ok[dr] && col_ok[dc] && (ri != 2'd3) && (ci != 2'd3)) begin
          nb[dr][dc] = win_q[ri][ci];
        end else begin
          nb[dr][dc] = '0;
        end
      end
    end
  end

  sobel_grad u_grad (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == StGrad),
    .nb_i    (nb),
    .valid_o (grad_valid),
    .sums_o  (grad_sums)
  );

  sobel_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (grad_valid),
    .s_i     (grad_sums),
    .done_o  (sqrt_done),
    .mag_o   (mag)
  );

  // ---------------------------------------------------------------------------
  // Sequencer. Results go out row by row, column by column within a row.
  // ---------------------------------------------------------------------------
  assign more_col = !csel_q && c_last_q;
  assign more_row = !rsel_q && r_last_q;
  assign last_res = !more_col && !more_row;
  assign out_load = (state_q == StEmit) && (!m_tvalid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    rsel_d  = rsel_q;
    csel_d  = csel_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        rsel_d = (r_q == '0);
        csel_d = (c_q == '0);
        if (((r_q != '0) || r_last_q) && ((c_q != '0) || c_last_q)) begin
          state_d = StGrad;
        end else begin
          state_d = StIdle;
        end
      end
      StGrad: begin
        state_d = StWait;
      end
      StWait: begin
        if (sqrt_done) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_load) begin
          if (more_col) begin
            csel_d  = 1'b1;
            state_d = StGrad;
          end else if (more_row) begin
            rsel_d  = 1'b1;
            csel_d  = (c_q == '0);
            state_d = StGrad;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rsel_q  <= 1'b0;
      csel_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rsel_q  <= rsel_d;
      csel_q  <= csel_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register. It frees the input side while a result waits.
  // ---------------------------------------------------------------------------
  assign out_row = r_q - RowW'(1) + RowW'(rsel_q);
  assign out_col = c_q - ColW'(1) + ColW'(csel_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (out_load) begin
      m_tvalid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_tdata_q <= {6'b0, ColOutW'(out_col), out_row, mag};
      m_tlast_q <= last_res;
    end
  end

  assign m_axis_tvalid_o = m_tvalid_q;
  assign m_axis_tdata_o  = m_tdata_q;
  assign m_axis_tlast_o  = m_tlast_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `SOBEL_ASSERT_IMP(a_sqrt_done_in_wait, sqrt_done, state_q == StWait, "square root finished outside Wait")
  `SOBEL_ASSERT_IMP(a_col_in_range, 1'b1, WdW'(col_cnt_q) < w_eff, "column counter beyond image width")
  `SOBEL_ASSERT_NXT(a_last_ends_item, out_load && last_res, state_q == StIdle, "final result did not release the input")

endmodule
`default_nettype wire

[tb/sobel_mag_checker.sv]
// Watches the configuration port and both pixel streams of the Sobel block.
// It predicts the magnitude results of every accepted input pixel and
// compares each result transfer with the oldest expected one.
module sobel_mag_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sobel_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sobel_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                            s_tvalid_i,
  input  logic                            s_tready_i,
  // tdata: in_pixel [23:0].
  input  logic [sobel_pkg::InTdataW-1:0]  s_tdata_i,
  input  logic                            m_tvalid_i,
  input  logic                            m_tready_i,
  // tdata: out_pixel [23:0], out_row [39:24], out_col [49:40].
  input  logic [sobel_pkg::OutTdataW-1:0] m_tdata_i,
  input  logic                            m_tlast_i,
  output int unsigned                     outstanding_o,
  output int unsigned                     fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import sobel_pkg::*;

  typedef struct packed {
    logic [PixW-1:0]    pixel;
    logic [RowW-1:0]    row;
    logic [ColOutW-1:0] col;
    logic               last;
  } mag_result_t;

  logic [WidthRegW-1:0]  width_reg;
  logic [HeightRegW-1:0] height_reg;
  logic [PixW-1:0]       upper_line [MaxWidthDef];
  logic [PixW-1:0]       lower_line [MaxWidthDef];
  logic [PixW-1:0]       win [3][3];
  int                    row_pos;
  int                    col_pos;
  mag_result_t           mag_q[$];
  int unsigned           fails = 0;
  int unsigned           owed = 0;

  assign outstanding_o = owed;
  assign fail_count_o  = fails;

  function automatic int active_width();
    if (width_reg == '0) return 1;
    if (int'(width_reg) > MaxWidthDef) return MaxWidthDef;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    return (height_reg == '0) ? 1 : int'(height_reg);
  endfunction

  // Nearest integer to the square root, saturated at full scale.
  function automatic logic [ChW-1:0] rounded_root(int s);
    int n;
    if (s > SatLimit) return ChMax;
    n = 0;
    while ((n + 1) * (n + 1) <= s) n++;
    if (s > n * n + n) n++;
    if (n > 255) n = 255;
    return ChW'(n);
  endfunction

  // Magnitude at (rc, cc); the window holds rows r-2..r and columns c-2..c.
  // Kernel weights: gx = dc scaled by 2 on the center row, gy = dr scaled by
  // 2 on the center column. Neighbors outside the image contribute nothing.
  function automatic logic [PixW-1:0] grad_pixel(int rc, int cc, int r, int c,
                                                 int h, int w);
    logic [PixW-1:0] pix_out;
    int gx, gy, rr, cl, wi, wj, v;
    pix_out = '0;
    for (int ch = 0; ch < NumCh; ch++) begin
      gx = 0;
      gy = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          rr = rc + dr;
          cl = cc + dc;
          wi = rr - (r - 2);
          wj = cl - (c - 2);
          if (rr >= 0 && rr < h && cl >= 0 && cl < w &&
              wi >= 0 && wi <= 2 && wj >= 0 && wj <= 2) begin
            v = int'(win[wi][wj][ch*ChW +: ChW]);
            gx += v * dc * ((dr == 0) ? 2 : 1);
            gy += v * dr * ((dc == 0) ? 2 : 1);
          end
        end
      end
      pix_out[ch*ChW +: ChW] = rounded_root(gx * gx + gy * gy);
    end
    return pix_out;
  endfunction

  task automatic predict_magnitudes(input logic [PixW-1:0] pix);
    int w, h, r, c, ci, nr, nc, total, k;
    int row_sel[2];
    int col_sel[2];
    mag_result_t res;
    w = active_width();
    h = active_height();
    r = row_pos;
    c = col_pos;
    if (r >= h || c >= w) begin
      r = 0;
      c = 0;
    end
    ci = c % MaxWidthDef;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = upper_line[ci];
    win[1][2] = lower_line[ci];
    win[2][2] = pix;
    upper_line[ci] = lower_line[ci];
    lower_line[ci] = pix;

    nr = 0;
    nc = 0;
    if (r >= 1) begin
      row_sel[nr] = r - 1;
      nr++;
    end
    if (r == h - 1) begin
      row_sel[nr] = r;
      nr++;
    end
    if (c >= 1) begin
      col_sel[nc] = c - 1;
      nc++;
    end
    if (c == w - 1) begin
      col_sel[nc] = c;
      nc++;
    end
    total = nr * nc;
    k = 0;
    for (int i = 0; i < nr; i++) begin
      for (int j = 0; j < nc; j++) begin
        res.pixel = grad_pixel(row_sel[i], col_sel[j], r, c, h, w);
        res.row   = RowW'(row_sel[i]);
        res.col   = ColOutW'(col_sel[j]);
        res.last  = (k == total - 1);
        mag_q.push_back(res);
        k++;
      end
    end

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_pos = r & 16'hFFFF;
    col_pos = c;
  endtask

  task automatic check_result();
    mag_result_t exp_res;
    if (mag_q.size() == 0) begin
      $error("result transfer with nothing expected: tdata %h tlast %b",
             m_tdata_i, m_tlast_i);
      fails++;
      return;
    end
    exp_res = mag_q.pop_front();
    if (m_tdata_i[23:0] !== exp_res.pixel) begin
      $error("out_pixel: expected %h, got %h", exp_res.pixel, m_tdata_i[23:0]);
      fails++;
    end
    if (m_tdata_i[39:24] !== exp_res.row) begin
      $error("out_row: expected %0d, got %0d", exp_res.row, m_tdata_i[39:24]);
      fails++;
    end
    if (m_tdata_i[49:40] !== exp_res.col) begin
      $error("out_col: expected %0d, got %0d", exp_res.col, m_tdata_i[49:40]);
      fails++;
    end
    if (m_tlast_i !== exp_res.last) begin
      $error("last_of_run: expected %b, got %b", exp_res.last, m_tlast_i);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg  = WidthRst;
      height_reg = HeightRst;
      row_pos    = 0;
      col_pos    = 0;
      for (int i = 0; i < MaxWidthDef; i++) begin
        upper_line[i] = '0;
        lower_line[i] = '0;
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) win[i][j] = '0;
      end
      mag_q.delete();
      owed = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgImageWidth: begin
            width_reg = cfg_wdata_i[WidthRegW-1:0];
            row_pos   = 0;
            col_pos   = 0;
          end
          CfgImageHeight: begin
            height_reg = cfg_wdata_i[HeightRegW-1:0];
            row_pos    = 0;
            col_pos    = 0;
          end
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) check_result();
      if (s_tvalid_i && s_tready_i) predict_magnitudes(s_tdata_i[PixW-1:0]);
      owed = mag_q.size();
    end
  end

endmodule

[tb/tb.sv]
// Top of the Sobel edge magnitude testbench. It drives clock, reset, the
// configuration port and the input pixel stream, and throttles the result
// stream. All prediction and comparison lives in the checker instance; this
// module only reads its failure count and the number of results still owed.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sobel_pkg::*;

  // Cycles to wait once nothing is owed: a pixel that releases no result may
  // still be in work.
  localparam int SettleCycles = 100;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx = '0;
  logic [CfgDataW-1:0]   cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [InTdataW-1:0]   s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OutTdataW-1:0]  m_tdata;
  logic                  m_tlast;
  int unsigned           owed;
  int unsigned           fails;

  // Percent of cycles in which the pixel source and the result sink hold off.
  int unsigned           src_idle_pct = 9;
  int unsigned           sink_idle_pct = 70;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sobel_edge_magnitude_rgb_top u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  sobel_mag_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tlast_i     (m_tlast),
    .outstanding_o (owed),
    .fail_count_o  (fails)
  );

  // The sink decides afresh on every falling edge whether it takes a result.
  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= sink_idle_pct);
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Offers one pixel, after a random number of idle cycles, and returns at
  // the falling edge that follows its transfer. tvalid stays high so that
  // back-to-back pixels need no gap; callers drop it at the end of a burst.
  task automatic send_pixel(input logic [PixW-1:0] pix);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering pixels and let every owed result arrive, then give the
  // block time to finish a pixel that releases nothing.
  task automatic settle();
    s_tvalid = 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx,
                           input logic [CfgDataW-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Any register write restarts the image, so both are written while idle.
  task automatic set_frame(input logic [CfgDataW-1:0] w_data,
                           input logic [CfgDataW-1:0] h_data);
    settle();
    write_reg(CfgImageWidth, w_data);
    write_reg(CfgImageHeight, h_data);
  endtask

  // A quarter of the pixels have every channel at an extreme, which drives
  // the gradients into saturation; the rest are fully random.
  function automatic logic [PixW-1:0] random_pixel();
    logic [PixW-1:0] pix;
    pix = PixW'($urandom);
    if ($urandom_range(3) == 0) begin
      for (int ch = 0; ch < NumCh; ch++) begin
        pix[ch*ChW +: ChW] = $urandom_range(1) ? ChMax : '0;
      end
    end
    return pix;
  endfunction

  initial begin
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned shape;
    logic [CfgDataW-1:0] w_data;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part. Two checkerboard rows of full-scale and black pixels
    // saturate every channel; the third row uses pure primaries.
    set_frame(16'd3, 16'd3);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);
    send_pixel(24'hFF0000);
    send_pixel(24'h00FF00);
    send_pixel(24'h0000FF);

    // A width of zero acts as a single column.
    set_frame(16'd0, 16'd2);
    send_pixel(24'hFFFFFF);
    send_pixel(24'h000000);

    // A height of zero acts as a single row, which is first and last at once.
    set_frame(16'd2, 16'd0);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);

    // Two more pixels than a 2x2 image holds: the counters wrap and a new
    // image begins without any register write.
    set_frame(16'd2, 16'd2);
    repeat (6) send_pixel(random_pixel());

    // All-ones writes: the width field is clipped to the maximum line length
    // and the height is at its top. The image is cut short by the next write.
    set_frame(16'hFFFF, 16'hFFFF);
    repeat (3) send_pixel(random_pixel());

    // Random part in three idling phases. Frames are small; some end early
    // and get restarted by the next write, some run on into the next image.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 9;
          sink_idle_pct = 70;
        end
        1: begin
          src_idle_pct  = 70;
          sink_idle_pct = 9;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < 55) begin
        w = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        h = $urandom_range(1, 5);
        // Unused upper bits of the width write sometimes carry junk.
        w_data = CfgDataW'(w);
        if ($urandom_range(3) == 0) w_data[15:11] = 5'($urandom_range(31));
        set_frame(w_data, CfgDataW'(h));
        n = w * h;
        shape = $urandom_range(9);
        if (shape < 2) n = $urandom_range(1, n);
        else if (shape == 2) n += $urandom_range(1, w * h);
        repeat (n) send_pixel(random_pixel());
        sent += n;
      end
    end

    settle();
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
